FILE: src/u8d_pkg.sv
package u8d_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] LEAD4_BITS  = 8'h07;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] contrib;
        logic            clear;
        logic            emit;
        logic            bad;
    } desc_t;

endpackage

FILE: src/u8d_if.sv
interface u8d_byte_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
    import u8d_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            bad_lead;

    modport source (output valid, output code_point, output bad_lead, input ready);
    modport sink (input valid, input code_point, input bad_lead, output ready);
endinterface

FILE: src/u8d_front.sv
module u8d_front
    import u8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] byte_data,
    output logic              desc_valid,
    input  logic              desc_ready,
    output desc_t             desc
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       take;

    assign byte_ready = desc_ready;
    assign desc_valid = byte_valid;
    assign take       = byte_valid && desc_ready;

    always_comb
    begin
        desc      = '0;
        pend_next = pend_reg;
        if (pend_reg != PEND_NONE)
        begin
            pend_next  = pend_reg - 2'd1;
            desc.emit  = (pend_reg == PEND_ONE);
            case (pend_reg)
                PEND_ONE:   desc.contrib = CP_W'(byte_data & CONT_BITS);
                PEND_TWO:   desc.contrib = CP_W'(byte_data & CONT_BITS) << 6;
                PEND_THREE: desc.contrib = CP_W'(byte_data & CONT_BITS) << 12;
                default:    desc.contrib = '0;
            endcase
        end
        else if (byte_data <= ASCII_MAX)
        begin
            desc.contrib = CP_W'(byte_data);
            desc.clear   = 1'b1;
            desc.emit    = 1'b1;
        end
        else if ((byte_data & LEAD2_MASK) == LEAD2_CODE)
        begin
            desc.contrib = CP_W'(byte_data & LEAD2_BITS) << 6;
            desc.clear   = 1'b1;
            pend_next    = PEND_ONE;
        end
        else if ((byte_data & LEAD3_MASK) == LEAD3_CODE)
        begin
            desc.contrib = CP_W'(byte_data & LEAD3_BITS) << 12;
            desc.clear   = 1'b1;
            pend_next    = PEND_TWO;
        end
        else if ((byte_data & LEAD4_MASK) == LEAD4_CODE)
        begin
            desc.contrib = CP_W'(byte_data & LEAD4_BITS) << 18;
            desc.clear   = 1'b1;
            pend_next    = PEND_THREE;
        end
        else
        begin
            desc.clear = 1'b1;
            desc.emit  = 1'b1;
            desc.bad   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
        end
        else if (take)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

FILE: src/u8d_fifo.sv
module u8d_fifo
    import u8d_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output desc_t pop_data,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t         store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/u8d_back.sv
module u8d_back
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            desc_valid,
    output logic            desc_pop,
    input  desc_t           desc,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CP_W-1:0] out_cp,
    output logic            out_bad
);

    logic            out_valid_reg;
    logic [CP_W-1:0] out_cp_reg;
    logic            out_bad_reg;
    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] value;

    assign desc_pop  = desc_valid && (!out_valid_reg || out_ready);
    assign value     = (desc.clear ? '0 : partial_reg) | desc.contrib;
    assign out_valid = out_valid_reg;
    assign out_cp    = out_cp_reg;
    assign out_bad   = out_bad_reg;

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            partial_reg <= value;
            if (desc.emit)
            begin
                out_cp_reg  <= value;
                out_bad_reg <= desc.bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (desc_pop && desc.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: src/utf8_byte_decoder_top.sv
// UTF-8 decoder: one byte per item on stream, one code point per item on result.
// Takes a byte every cycle while the queue has room. A code point is offered on
// result after its last byte is taken: the front classifies the byte and writes
// the queue in the cycle it is taken, and the back pops it from the queue and
// assembles it into the output register when result is not stalled. ASCII bytes
// and bad lead bytes (10xxxxxx or 11111xxx with nothing pending) give one item
// each, bad leads with code_point 0 and bad_lead set; lead bytes and inner
// continuation bytes give none. Continuation bytes are not checked, and a cut
// sequence stays open until enough bytes arrive. QUEUE_DEPTH sets how many
// classified bytes can wait between front and back.
module utf8_byte_decoder_top
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    u8d_byte_if.sink    stream,
    u8d_cp_if.source    result
);

    desc_t front_desc;
    desc_t back_desc;
    logic  front_valid;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  q_push;

    assign q_push = front_valid && !q_full;

    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (stream.valid),
        .byte_ready (stream.ready),
        .byte_data  (stream.in_byte),
        .desc_valid (front_valid),
        .desc_ready (!q_full),
        .desc       (front_desc)
    );

    u8d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_desc),
        .empty     (q_empty)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (!q_empty),
        .desc_pop   (q_pop),
        .desc       (back_desc),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_cp     (result.code_point),
        .out_bad    (result.bad_lead)
    );

`ifndef NO_ASSERTIONS
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.bad_lead |-> result.code_point == '0)
        else $error("bad lead item with nonzero code point");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("queue popped while empty");

    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        stream.valid && stream.ready |-> q_push)
        else $error("byte taken without a queue slot");
`endif

endmodule
